// ===== design/tsfp_pkg.sv =====
package tsfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned PRESSURE_W = 13;
  localparam int unsigned SUM_W      = 14;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned HOLD_W     = 7;
  localparam int unsigned ORIENT_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [PRESSURE_W-1:0] pressure_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [ORIENT_W-1:0]   orient_t;

  localparam coord_t    FULL_SCALE         = 12'd4095;
  localparam pos_t      LAST_POS           = 5'd24;
  localparam pos_t      IDLE_POS           = 5'd25;
  localparam pos_t      Z1_POS             = 5'd2;
  localparam pos_t      Z2_POS             = 5'd4;
  localparam pos_t      FIRST_X_POS        = 5'd10;
  localparam pos_t      FIRST_Y_POS        = 5'd12;
  localparam pressure_t THRESHOLD_RESET    = 13'd300;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 1'b1;

  localparam orient_t ORIENT_0   = 2'd0;
  localparam orient_t ORIENT_90  = 2'd1;
  localparam orient_t ORIENT_180 = 2'd2;
  localparam orient_t ORIENT_270 = 2'd3;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Maps the averaged panel readings onto display coordinates.
  function automatic point_t orient_point(coord_t ax, coord_t ay, orient_t orient);
    point_t p;
    unique case (orient)
      ORIENT_0: begin
        p.x = ay;
        p.y = ax;
      end
      ORIENT_90: begin
        p.x = ax;
        p.y = FULL_SCALE - ay;
      end
      ORIENT_180: begin
        p.x = FULL_SCALE - ay;
        p.y = FULL_SCALE - ax;
      end
      default: begin
        p.x = FULL_SCALE - ax;
        p.y = ay;
      end
    endcase
    return p;
  endfunction

endpackage

// ===== design/touch_sample_frame_processor.sv =====
// Resistive touch frame processor.
// Input stream: one converter byte per transaction on in_tdata; in_tuser high
// marks the first byte of a 25-byte read frame and restarts the byte count.
// Bytes after the 25th are dropped until the next frame start.
// Output stream: one result per complete frame, issued from a result register
// in the cycle after the last byte is accepted. out_tuser is the touched flag;
// out_tdata carries the held x, y and pressure.
// Throughput is one byte per cycle while in_tready is high: readings are accumulated
// as they arrive and the frame result is formed in a single pass on the last byte.
// When the receiver stalls, the result register holds; input bytes keep being
// taken, and in_tready drops only when the next byte could close a frame while
// the previous result is still pending.
// Configuration writes (threshold, orientation) take effect at the next edge.
// Reset (synchronous, rst_n low) clears the byte count, sums and held values,
// sets the threshold to 300 and orientation to 0, and empties the result
// register.
module touch_sample_frame_processor
  import tsfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [11:0] touch_x, [23:12] touch_y,
                                            // [36:24] pressure, [39:37] zero
  output logic                  out_tuser,  // [0] touched
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pressure_t           threshold_r;
  orient_t             orient_r;
  pos_t                pos_r, pos_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  coord_t              z1_r, z1_nxt;
  coord_t              z2_r, z2_nxt;
  sum_t                xsum_r, xsum_nxt;
  sum_t                ysum_r, ysum_nxt;
  coord_t              held_x_r, held_x_nxt;
  coord_t              held_y_r, held_y_nxt;
  pressure_t           held_p_r, held_p_nxt;

  logic                out_valid_r;
  logic                out_touched_r;
  coord_t              out_x_r, out_y_r;
  pressure_t           out_p_r;

  logic                accept;
  logic                emit;
  pos_t                eff_pos;
  coord_t              reading;
  pressure_t           z;
  logic                ok;
  point_t              pt;

  assign in_tready = !(out_valid_r && !out_tready && (pos_r == LAST_POS));
  assign accept    = in_tvalid && in_tready;
  assign eff_pos   = in_tuser ? '0 : pos_r;
  assign reading   = {hold_r, in_tdata[7:3]};
  assign emit      = accept && (eff_pos == LAST_POS);

  assign z  = PRESSURE_W'(z1_r) + PRESSURE_W'(FULL_SCALE) - PRESSURE_W'(z2_r);
  assign ok = (z >= threshold_r);
  assign pt = orient_point(xsum_nxt[SUM_W-1:2], ysum_nxt[SUM_W-1:2], orient_r);

  always_comb begin
    pos_nxt    = pos_r;
    hold_nxt   = hold_r;
    z1_nxt     = z1_r;
    z2_nxt     = z2_r;
    xsum_nxt   = xsum_r;
    ysum_nxt   = ysum_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    held_p_nxt = held_p_r;
    if (accept) begin
      if (eff_pos > LAST_POS) begin
        pos_nxt = eff_pos;
      end else begin
        pos_nxt = eff_pos + 1'b1;
        if (eff_pos == '0) begin
          xsum_nxt = '0;
          ysum_nxt = '0;
        end else if (eff_pos[0]) begin
          hold_nxt = in_tdata[HOLD_W-1:0];
        end else if (eff_pos == Z1_POS) begin
          z1_nxt = reading;
        end else if (eff_pos == Z2_POS) begin
          z2_nxt = reading;
        end else if (eff_pos >= FIRST_X_POS && eff_pos[1:0] == 2'd2) begin
          xsum_nxt = xsum_r + SUM_W'(reading);
        end else if (eff_pos >= FIRST_Y_POS && eff_pos[1:0] == 2'd0) begin
          ysum_nxt = ysum_r + SUM_W'(reading);
        end
      end
    end
    // The last byte's Y reading is already folded into ysum_nxt here.
    if (emit && ok) begin
      held_x_nxt = pt.x;
      held_y_nxt = pt.y;
      held_p_nxt = z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      orient_r    <= ORIENT_0;
      pos_r       <= '0;
      hold_r      <= '0;
      z1_r        <= '0;
      z2_r        <= '0;
      xsum_r      <= '0;
      ysum_r      <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_p_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD:   threshold_r <= cfg_data;
          CFG_ORIENTATION: orient_r    <= cfg_data[ORIENT_W-1:0];
          default: ;
        endcase
      end
      pos_r    <= pos_nxt;
      hold_r   <= hold_nxt;
      z1_r     <= z1_nxt;
      z2_r     <= z2_nxt;
      xsum_r   <= xsum_nxt;
      ysum_r   <= ysum_nxt;
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
      held_p_r <= held_p_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_touched_r <= ok;
      out_x_r       <= held_x_nxt;
      out_y_r       <= held_y_nxt;
      out_p_r       <= held_p_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_touched_r;
  assign out_tdata  = {3'b000, out_p_r, out_y_r, out_x_r};

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= IDLE_POS)
    else $error("byte position out of range");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tuser && (pos_r == LAST_POS) |=> out_valid_r)
    else $error("frame end did not produce a result");

  a_stall_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && (pos_r == LAST_POS))
    else $error("input stalled without a pending frame end");

  a_touch_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    emit && ok |=> out_valid_r && out_tuser && (out_p_r >= threshold_r))
    else $error("touched result below threshold");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import tsfp_pkg::*;

  typedef struct packed {
    logic      touched;
    coord_t    x;
    coord_t    y;
    pressure_t pres;
  } touch_report_t;

  typedef logic [3:0][COORD_W-1:0] readings_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;   // [7:0] rx_byte
  logic                  in_tuser   = 1'b0; // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [11:0] x, [23:12] y, [36:24] pressure
  logic                  out_tuser;         // [0] touched
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Shadow copy of the block's registers and frame state.
  pressure_t         touch_threshold = THRESHOLD_RESET;
  orient_t           touch_orient    = ORIENT_0;
  pos_t              frame_pos       = '0;
  logic [HOLD_W-1:0] high_hold       = '0;
  coord_t            z1_val          = '0;
  coord_t            z2_val          = '0;
  sum_t              x_acc           = '0;
  sum_t              y_acc           = '0;
  coord_t            held_x          = '0;
  coord_t            held_y          = '0;
  pressure_t         held_pres       = '0;

  touch_report_t expected_touches[$];
  int unsigned   error_count   = 0;
  int unsigned   counted_bytes = 0;
  int unsigned   in_gap_max    = 17;
  int unsigned   out_gap_max   = 17;

  touch_sample_frame_processor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (error_count < 100) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    error_count++;
  endtask

  // Advances the shadow state by one accepted byte and queues the frame report
  // when the byte closes a frame.
  task automatic predict_touch_byte(input logic [BYTE_W-1:0] b, input logic start);
    pos_t          pos;
    coord_t        rd;
    coord_t        ax;
    coord_t        ay;
    coord_t        nx;
    coord_t        ny;
    int unsigned   z;
    touch_report_t rep;
    if (start) begin
      frame_pos = '0;
    end
    pos = frame_pos;
    if (pos > LAST_POS) begin
      return;
    end
    frame_pos = pos + 1'b1;
    if (pos == '0) begin
      x_acc = '0;
      y_acc = '0;
      return;
    end
    if (pos[0]) begin
      high_hold = b[6:0];
      return;
    end
    rd = {high_hold, b[7:3]};
    if (pos == Z1_POS) begin
      z1_val = rd;
    end else if (pos == Z2_POS) begin
      z2_val = rd;
    end else if (pos >= FIRST_X_POS && pos[1:0] == 2'd2) begin
      x_acc = x_acc + rd;
    end else if (pos >= FIRST_Y_POS && pos[1:0] == 2'd0) begin
      y_acc = y_acc + rd;
    end
    if (pos != LAST_POS) begin
      return;
    end
    z = z1_val + 4095 - z2_val;
    rep.touched = (z >= touch_threshold);
    if (rep.touched) begin
      ax = x_acc[SUM_W-1:2];
      ay = y_acc[SUM_W-1:2];
      case (touch_orient)
        ORIENT_0: begin
          nx = ay;
          ny = ax;
        end
        ORIENT_90: begin
          nx = ax;
          ny = FULL_SCALE - ay;
        end
        ORIENT_180: begin
          nx = FULL_SCALE - ay;
          ny = FULL_SCALE - ax;
        end
        default: begin
          nx = FULL_SCALE - ax;
          ny = ay;
        end
      endcase
      held_x    = nx;
      held_y    = ny;
      held_pres = z[PRESSURE_W-1:0];
    end
    rep.x    = held_x;
    rep.y    = held_y;
    rep.pres = held_pres;
    expected_touches.push_back(rep);
  endtask

  // Returns right after the edge that accepts the byte, so that a following
  // byte with no gap keeps in_tvalid high without dropping it in between.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    counted_bytes++;
    predict_touch_byte(b, start);
  endtask

  // Sends the first n_bytes of a read frame whose Z readings give the target
  // pressure. Bit 7 of each high byte and the three spare low bits are random.
  task automatic send_frame(input logic start, input int unsigned target,
                            input readings_t xs, input readings_t ys,
                            input int unsigned n_bytes);
    logic [BYTE_W-1:0] fb [25];
    coord_t            rd [12];
    int unsigned       z1;
    int unsigned       z2;
    logic              b7;
    logic [2:0]        spare;
    if (target >= 4095) begin
      z2 = $urandom_range(0, 8190 - target);
      z1 = target - 4095 + z2;
    end else begin
      z1 = $urandom_range(0, target);
      z2 = z1 + 4095 - target;
    end
    rd[0] = z1[COORD_W-1:0];
    rd[1] = z2[COORD_W-1:0];
    rd[2] = COORD_W'($urandom_range(0, 4095));
    rd[3] = COORD_W'($urandom_range(0, 4095));
    for (int k = 0; k < 4; k++) begin
      rd[4 + 2 * k] = xs[k];
      rd[5 + 2 * k] = ys[k];
    end
    fb[0] = BYTE_W'($urandom_range(0, 255));
    for (int i = 0; i < 12; i++) begin
      b7    = 1'($urandom_range(0, 1));
      spare = 3'($urandom_range(0, 7));
      fb[1 + 2 * i] = {b7, rd[i][11:5]};
      fb[2 + 2 * i] = {rd[i][4:0], spare};
    end
    for (int i = 0; i < n_bytes; i++) begin
      send_byte(fb[i], start && (i == 0));
    end
  endtask

  function automatic readings_t rand_readings();
    readings_t r;
    case ($urandom_range(0, 7))
      0:       r = '0;
      1:       r = '1;
      default: begin
        for (int k = 0; k < 4; k++) begin
          r[k] = COORD_W'($urandom_range(0, 4095));
        end
      end
    endcase
    return r;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    if (idx == CFG_THRESHOLD) begin
      touch_threshold = value[PRESSURE_W-1:0];
    end else begin
      touch_orient = value[ORIENT_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender off until every frame report has come out and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_touches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_frame_without_start();
    send_frame(1'b0, 8190, {4{12'd4095}}, '0, 25);
  endtask

  task automatic test_rejected_touch();
    send_frame(1'b1, 0, rand_readings(), rand_readings(), 25);
    send_frame(1'b1, 299, rand_readings(), rand_readings(), 25);
    send_frame(1'b1, 300, rand_readings(), rand_readings(), 25);
  endtask

  task automatic test_orientations();
    for (int o = 0; o < 4; o++) begin
      wait_idle();
      write_register(CFG_ORIENTATION, o);
      send_frame(1'b1, 4000 + o, rand_readings(), rand_readings(), 25);
    end
  endtask

  task automatic test_threshold_extremes();
    wait_idle();
    write_register(CFG_THRESHOLD, 0);
    send_frame(1'b1, 0, rand_readings(), rand_readings(), 25);
    wait_idle();
    write_register(CFG_THRESHOLD, 8190);
    send_frame(1'b1, 8190, rand_readings(), rand_readings(), 25);
    send_frame(1'b1, 8189, rand_readings(), rand_readings(), 25);
    wait_idle();
    write_register(CFG_THRESHOLD, 300);
  endtask

  task automatic test_resync();
    // A start in the middle of a frame drops the partial frame.
    send_frame(1'b1, 5000, rand_readings(), rand_readings(), 11);
    send_frame(1'b1, 5000, rand_readings(), rand_readings(), 25);
    // Bytes after a complete frame are ignored until the next start.
    for (int i = 0; i < 5; i++) begin
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    end
    send_frame(1'b1, 6000, rand_readings(), rand_readings(), 25);
  endtask

  task automatic test_random_traffic();
    int unsigned frames_left;
    int unsigned target;
    int          t;
    frames_left = 0;
    while (counted_bytes < 1650) begin
      if (frames_left == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0:       write_register(CFG_THRESHOLD, 0);
          1:       write_register(CFG_THRESHOLD, 8190);
          default: write_register(CFG_THRESHOLD, $urandom_range(0, 8190));
        endcase
        write_register(CFG_ORIENTATION, $urandom_range(0, 3));
        frames_left = $urandom_range(8, 16);
      end
      frames_left--;
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 17;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      if ($urandom_range(0, 2) == 0) begin
        t = int'(touch_threshold) + int'($urandom_range(0, 4)) - 2;
        target = (t < 0) ? 0 : ((t > 8190) ? 8190 : t);
      end else begin
        target = $urandom_range(0, 8190);
      end
      case ($urandom_range(0, 9))
        0: begin
          for (int i = $urandom_range(1, 12); i > 0; i--) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
          end
        end
        1: send_frame(1'b1, target, rand_readings(), rand_readings(), $urandom_range(1, 24));
        default: begin
          send_frame(1'b1, target, rand_readings(), rand_readings(), 25);
          if ($urandom_range(0, 4) == 0) begin
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
              send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
          end
        end
      endcase
    end
    in_gap_max  = 17;
    out_gap_max = 17;
  endtask

  // Result side: a random number of stalled cycles before each result.
  initial begin
    int unsigned stall;
    forever begin
      stall = $urandom_range(0, out_gap_max);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    touch_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_touches.size() == 0) begin
        report_mismatch("frame result with no frame outstanding");
      end else begin
        want = expected_touches.pop_front();
        if (out_tuser !== want.touched) begin
          report_mismatch($sformatf("touched %0b, expected %0b", out_tuser, want.touched));
        end
        if (out_tdata[11:0] !== want.x) begin
          report_mismatch($sformatf("touch_x %0d, expected %0d", out_tdata[11:0], want.x));
        end
        if (out_tdata[23:12] !== want.y) begin
          report_mismatch($sformatf("touch_y %0d, expected %0d", out_tdata[23:12], want.y));
        end
        if (out_tdata[36:24] !== want.pres) begin
          report_mismatch($sformatf("pressure %0d, expected %0d",
                                    out_tdata[36:24], want.pres));
        end
        if (out_tdata[39:37] !== 3'b000) begin
          report_mismatch($sformatf("padding bits %b not zero", out_tdata[39:37]));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_frame_without_start();
    test_rejected_touch();
    test_orientations();
    test_threshold_extremes();
    test_resync();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== touch_sample_frame_processor.f =====
design/tsfp_pkg.sv
design/touch_sample_frame_processor.sv
tb/sv/testbench.sv
